// ===== sv/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation engine.
// ----------------------------------------------------------------------------
`default_nettype none
package mexp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDB,
    ST_SQR,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_REDB,
    OP_SQR,
    OP_MUL
  } op_e;

  localparam logic CFG_MODULUS  = 1'b0;
  localparam logic CFG_EXPONENT = 1'b1;

  typedef struct packed {
    logic load;
    logic go;
    op_e  op;
  } mexp_cmd_t;

  typedef struct packed {
    logic busy;
  } mexp_sts_t;

endpackage
`default_nettype wire

// ===== sv/mexp_dp.sv =====
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: operand registers, one multiplier and a shift-subtract reducer.
// ----------------------------------------------------------------------------
`default_nettype none
module mexp_dp import mexp_pkg::*; #(
  parameter int MOD_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mexp_cmd_t            cmd_i,
  input  wire logic [31:0]          base_i,
  input  wire logic [MOD_WIDTH-1:0] modulus_i,
  input  wire logic                 odd_i,
  output mexp_sts_t                 sts_o,
  output logic [MOD_WIDTH-1:0]      acc_o
);

  localparam int PW = 2 * MOD_WIDTH;
  localparam int CW = $clog2(PW + 1);
  localparam int XW = (PW > 32) ? PW : 32;

  logic [MOD_WIDTH-1:0] b_q, b_d, acc_q, acc_d;
  logic [XW-1:0]        x_q, x_d;
  logic [MOD_WIDTH:0]   r_q, r_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 run_q, run_d;
  op_e                  op_q, op_d;
  logic [MOD_WIDTH:0]   trial, mext;
  logic [MOD_WIDTH-1:0] sq_lo_q, sq_lo;
  logic [MOD_WIDTH-1:0] mul_a;
  logic [PW-1:0]        prod;

  assign mext = {1'b0, modulus_i};
  assign sq_lo = sq_lo_q;

  // Share one multiplier: square the base or multiply it into the accumulator.
  assign mul_a = (cmd_i.op == OP_SQR) ? b_q : acc_q;
  assign prod  = PW'(mul_a) * PW'(b_q);

  always_comb begin
    b_d = b_q; acc_d = acc_q; x_d = x_q; r_d = r_q;
    cnt_d = cnt_q; run_d = run_q; op_d = op_q;
    trial = {r_q[MOD_WIDTH-1:0], x_q[XW-1]};
    if (cmd_i.load) begin
      acc_d = MOD_WIDTH'(1);
    end
    if (cmd_i.go) begin
      op_d  = cmd_i.op;
      run_d = 1'b1;
      cnt_d = CW'(PW);
      r_d   = '0;
      case (cmd_i.op)
        OP_REDB: x_d = XW'(base_i) << (XW - 32);
        OP_SQR:  x_d = XW'(prod) << (XW - PW);
        OP_MUL:  x_d = XW'(prod) << (XW - PW);
        default: x_d = '0;
      endcase
      // A base reduction processes only the 32 bits of the base.
      if (cmd_i.op == OP_REDB) cnt_d = CW'(32);
    end else if (run_q) begin
      if (cnt_q != '0) begin
        // One restoring-division step per cycle.
        r_d = (trial >= mext) ? trial - mext : trial;
        x_d = {x_q[XW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
      end else begin
        run_d = 1'b0;
        if (op_q == OP_REDB) begin
          b_d = (modulus_i == '0) ? base_i[MOD_WIDTH-1:0] : r_q[MOD_WIDTH-1:0];
          acc_d = odd_i ? ((modulus_i == '0) ? base_i[MOD_WIDTH-1:0]
                  : r_q[MOD_WIDTH-1:0])
                  : ((modulus_i == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1));
        end else if (op_q == OP_SQR) begin
          b_d = (modulus_i == '0) ? sq_lo : r_q[MOD_WIDTH-1:0];
        end else begin
          acc_d = (modulus_i == '0) ? sq_lo : r_q[MOD_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      op_q  <= OP_NONE;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      op_q  <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d; acc_q <= acc_d; x_q <= x_d; r_q <= r_d;
    if (cmd_i.go) begin
      sq_lo_q <= prod[MOD_WIDTH-1:0];
    end
  end

  assign sts_o.busy = run_q | cmd_i.go;
  assign acc_o = acc_q;

endmodule
`default_nettype wire

// ===== sv/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: scans exponent bits and sequences datapath operations.
// ----------------------------------------------------------------------------
`default_nettype none
module mexp_ctrl import mexp_pkg::*; #(
  parameter int EXP_WIDTH = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [EXP_WIDTH-1:0] exponent_i,
  input  wire mexp_sts_t            sts_i,
  output mexp_cmd_t                 cmd_o,
  output logic                      busy_o,
  output logic                      done_o,
  output logic                      one_o
);

  localparam int IW = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

  state_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic issued_q, issued_d;
  logic one_q, one_d;
  logic bit_set;

  assign bit_set = exponent_i[idx_q];

  always_comb begin
    state_d = state_q; idx_d = idx_q; issued_d = issued_q; one_d = one_q;
    case (state_q)
      ST_IDLE: if (start_i) begin
        one_d = (exponent_i == '0);
        idx_d = '0;
        issued_d = 1'b0;
        state_d = (exponent_i == '0) ? ST_DONE : ST_REDB;
      end
      ST_REDB, ST_SQR, ST_MUL: begin
        if (!issued_q) issued_d = 1'b1;
        else if (!sts_i.busy) begin
          issued_d = 1'b0;
          if (state_q == ST_SQR && bit_set) state_d = ST_MUL;
          else if (32'(idx_q) == EXP_WIDTH - 1) state_d = ST_DONE;
          else begin
            idx_d = idx_q + 1'b1;
            state_d = ST_SQR;
          end
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load = (state_q == ST_IDLE) && start_i;
    cmd_o.go = 1'b0;
    cmd_o.op = OP_NONE;
    case (state_q)
      ST_REDB: begin cmd_o.go = !issued_q; cmd_o.op = OP_REDB; end
      ST_SQR:  begin cmd_o.go = !issued_q; cmd_o.op = OP_SQR;  end
      ST_MUL:  begin cmd_o.go = !issued_q; cmd_o.op = OP_MUL;  end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  assign one_o  = one_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; idx_q <= '0; issued_q <= 1'b0; one_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; issued_q <= issued_d; one_q <= one_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply engine: power_mod = base^exponent mod modulus.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to launch one transaction; done_o goes high
// for exactly one cycle with the result on power_mod_o and cannot be stalled.
// A transaction runs one base reduction, EXP_WIDTH-1 squarings and one multiply
// per set exponent bit above bit 0, each through the one-bit-per-cycle
// shift-subtract reducer. Exponent zero skips the datapath and goes straight
// to done. Write modulus (index 0) and exponent (index 1) only while busy is
// low; modulus zero acts as 2^MOD_WIDTH.
`default_nettype none
module modular_exponentiation import mexp_pkg::*; #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 7
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] base_i,
  output logic             done_o,
  output logic [31:0]      power_mod_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [MOD_WIDTH-1:0] modulus_q;
  logic [EXP_WIDTH-1:0] exponent_q;
  logic [31:0]          base_q;
  mexp_cmd_t            cmd;
  mexp_sts_t            sts;
  logic [MOD_WIDTH-1:0] acc;
  logic                 one;

  assign cfg_ready_o = 1'b1;

  // Hold configuration; latch the base when a transaction starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MOD_WIDTH'(1);
      exponent_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MODULUS)  modulus_q  <= cfg_data_i[MOD_WIDTH-1:0];
      if (cfg_index_i == CFG_EXPONENT) exponent_q <= cfg_data_i[EXP_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) base_q <= base_i;
  end

  mexp_ctrl #(.EXP_WIDTH(EXP_WIDTH)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .exponent_i(exponent_q), .sts_i(sts),
    .cmd_o(cmd), .busy_o(busy), .done_o(done_o), .one_o(one)
  );

  mexp_dp #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .base_i(base_q), .modulus_i(modulus_q),
    .odd_i(exponent_q[0]), .sts_o(sts), .acc_o(acc)
  );

  // Exponent zero always yields one, modulus one included.
  assign power_mod_o = one ? 32'd1 : 32'(acc);

endmodule
`default_nettype wire
